// File: sv/hse_pkg.sv
`default_nettype none

package hse_pkg;

   // default sizes of the sorter
   localparam int DEPTH_DEFAULT     = 64;
   localparam int KEY_WIDTH_DEFAULT = 32;

   // fixed widths of the port fields
   localparam int PORT_KEY_WIDTH = 32;

   // per-cycle command broadcast to every cell of the row
   typedef struct packed {
      logic insert;   // place the incoming key into the ordered row
      logic shift;    // move every key one cell toward the head
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: sv/heap_sort_engine.sv
// channel   | ports                                          | transfer when
// ----------+------------------------------------------------+---------------------------
// request   | start, busy, req_key_value, req_batch_end      | start high and busy low
// response  | rsp_valid, rsp_sorted_key, rsp_final_flag,     | every cycle rsp_valid is high
//           | rsp_dropped_flag                               |
//
// a key is taken on each request transfer; the row of cells keeps the batch in ascending order
// as it arrives, so no separate sort pass is needed.
// after the batch end transfer the block is busy while it sends out the N keys held
// (at most DEPTH), one result per cycle.
// reset is synchronous and active high; it clears the fill count, overflow flag and state.
// the receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module heap_sort_engine #(
   parameter int DEPTH     = hse_pkg::DEPTH_DEFAULT,
   parameter int KEY_WIDTH = hse_pkg::KEY_WIDTH_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire  [hse_pkg::PORT_KEY_WIDTH-1:0]   req_key_value,
   input  wire                                  req_batch_end,
   output logic                                 rsp_valid,
   output logic [hse_pkg::PORT_KEY_WIDTH-1:0]   rsp_sorted_key,
   output logic                                 rsp_final_flag,
   output logic                                 rsp_dropped_flag
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = hse_pkg::PORT_KEY_WIDTH;

   // state codes
   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic          state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          overflow_ff, overflow_in;

   logic          accept;
   logic          has_room;
   logic          last_out;

   hse_pkg::cell_ctrl_type ctrl;

   logic [KEY_WIDTH-1:0] key_trim;
   logic [KEY_WIDTH-1:0] cell_key  [DEPTH];
   logic [DEPTH-1:0]     cell_keep;
   logic [DEPTH-1:0]     cell_occ;

   // bring the port key to the stored width
   generate
      if (KEY_WIDTH > PW) begin : g_key_wide
         assign key_trim = {{(KEY_WIDTH-PW){1'b0}}, req_key_value};
         assign rsp_sorted_key = cell_key[0][PW-1:0];
      end else if (KEY_WIDTH == PW) begin : g_key_same
         assign key_trim = req_key_value;
         assign rsp_sorted_key = cell_key[0];
      end else begin : g_key_narrow
         assign key_trim = req_key_value[KEY_WIDTH-1:0];
         assign rsp_sorted_key = {{(PW-KEY_WIDTH){1'b0}}, cell_key[0]};
      end
   endgenerate

   assign busy     = (state_ff == ST_DRAIN);
   assign accept   = start && !busy;
   assign has_room = (count_ff < CW'(DEPTH));
   assign last_out = (count_ff == CW'(1));

   always_comb begin
      ctrl.insert = accept && has_room;
      ctrl.shift  = busy;
   end

   // row of cells: cell 0 holds the smallest key, filled cells are below count_ff
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic                 prev_keep;
         logic [KEY_WIDTH-1:0] prev_key;
         logic [KEY_WIDTH-1:0] next_key;

         assign cell_occ[i] = (CW'(i) < count_ff);

         if (i == 0) begin : g_head
            // virtual cell in front of the row always keeps its place
            assign prev_keep = 1'b1;
            assign prev_key  = key_trim;
         end else begin : g_body
            assign prev_keep = cell_keep[i-1];
            assign prev_key  = cell_key[i-1];
         end

         if (i == DEPTH-1) begin : g_tail
            assign next_key = cell_key[i];
         end else begin : g_inner
            assign next_key = cell_key[i+1];
         end

         hse_cell #(
            .KEY_WIDTH (KEY_WIDTH)
         ) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .occupied  (cell_occ[i]),
            .ins_key   (key_trim),
            .prev_keep (prev_keep),
            .prev_key  (prev_key),
            .next_key  (next_key),
            .keep      (cell_keep[i]),
            .key_out   (cell_key[i])
         );
      end
   endgenerate

   // load keys until the batch end, then stream the row out from its head
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (has_room) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;   // store full, key is dropped
               end
               if (req_batch_end) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            count_in = count_ff - CW'(1);
            if (last_out) begin
               state_in    = ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // results come straight from the head cell while draining
   assign rsp_valid        = busy;
   assign rsp_final_flag   = busy && last_out;
   assign rsp_dropped_flag = overflow_ff;

endmodule

`default_nettype wire

// File: sv/hse_cell.sv
`default_nettype none

module hse_cell #(
   parameter int KEY_WIDTH = hse_pkg::KEY_WIDTH_DEFAULT
) (
   input  wire                      clock,
   input  hse_pkg::cell_ctrl_type   ctrl,
   input  wire                      occupied,
   input  wire  [KEY_WIDTH-1:0]     ins_key,
   input  wire                      prev_keep,
   input  wire  [KEY_WIDTH-1:0]     prev_key,
   input  wire  [KEY_WIDTH-1:0]     next_key,
   output logic                     keep,
   output logic [KEY_WIDTH-1:0]     key_out
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;

   // an empty cell behaves as larger than any key
   always_comb begin
      keep = occupied && (key_ff <= ins_key);
   end

   always_comb begin
      key_in = key_ff;
      if (ctrl.shift) begin
         key_in = next_key;
      end else if (ctrl.insert && !keep) begin
         // first larger cell takes the new key, the rest move up by one
         key_in = prev_keep ? ins_key : prev_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out = key_ff;

endmodule

`default_nettype wire
